FILE: rtl/core/rap_pkg.sv
// Package for the RTP AAC packetizer: shared types and header constants.
`timescale 1ns / 1ps
`default_nettype none
package rap_pkg;

    localparam int HDR_BYTES   = 16;
    localparam int POS_W       = $clog2(HDR_BYTES + 1);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] RTP_VER_BYTE  = 8'h80;
    localparam logic [7:0] MARKER_BIT    = 8'h80;
    localparam logic [6:0] PT_MASK       = 7'h7F;
    localparam logic [7:0] AU_HDR_LEN_HI = 8'h00;
    localparam logic [7:0] AU_HDR_LEN_LO = 8'h10;
    localparam logic [4:0] LEN_LO_MASK   = 5'h1F;

    localparam logic REG_PAYLOAD_TYPE = 1'b0;
    localparam logic REG_SOURCE_ID    = 1'b1;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_start;
        logic        frame_end;
        logic [12:0] frame_length;
        logic [31:0] frame_time;
        logic [15:0] seq;
    } t_entry;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] source_id;
    } t_cfg;

endpackage
`default_nettype wire

FILE: rtl/core/rtp_aac_au_packetizer_core.sv
// Top level of the RTP AAC access unit packetizer with its register port.
//
// Input channel (i_valid/o_ready) carries one payload byte per item with
// frame_start, frame_length, frame_time and frame_end. Output channel
// (o_valid/i_ready) carries one packet byte per item with packet_end.
// An item with frame_start produces 16 header bytes (RTP header with
// marker set, then the AU header section) followed by its payload byte;
// any other item produces just its byte.
// Path: an accepted item goes through the queue, then the output register.
// Throughput: one output byte per cycle, set by the back-end sequencer, while
// the queue holds an item and the receiver does not stall.
// A 4-entry queue decouples the input side, so o_ready stays high until
// the queue fills during header emission.
// Receiver stall: the output register holds its byte; the sequencer and
// then the queue fill, and o_ready drops.
// Reset (synchronous, active low): sequence number 0, payload_type 96,
// source_id 0, queue and output empty.
// Registers: 0x0 payload_type[6:0], 0x4 source_id[31:0]; write when idle.
`timescale 1ns / 1ps
`default_nettype none
module rtp_aac_au_packetizer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_frame_start,
    input  wire logic [12:0] i_frame_length,
    input  wire logic [31:0] i_frame_time,
    input  wire logic        i_frame_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_packet_byte,
    output logic             o_packet_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rap_pkg::*;

    t_cfg   r_cfg;
    t_entry push_entry;
    t_entry head;
    logic   push;
    logic   full;
    logic   pop;
    logic   nonempty;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_type <= 7'd96;
            r_cfg.source_id    <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_PAYLOAD_TYPE: r_cfg.payload_type <= pwdata[6:0];
                REG_SOURCE_ID:    r_cfg.source_id    <= pwdata;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PAYLOAD_TYPE: prdata = {25'd0, r_cfg.payload_type};
            REG_SOURCE_ID:    prdata = r_cfg.source_id;
            default:          prdata = '0;
        endcase
    end

    rap_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_payload_byte (i_payload_byte),
        .i_frame_start  (i_frame_start),
        .i_frame_length (i_frame_length),
        .i_frame_time   (i_frame_time),
        .i_frame_end    (i_frame_end),
        .i_full         (full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    rap_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    rap_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_nonempty    (nonempty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_packet_byte (o_packet_byte),
        .o_packet_end  (o_packet_end)
    );

endmodule
`default_nettype wire

FILE: rtl/core/rap_front.sv
// Front end: accepts input items, tags frame starts with a sequence number.
`timescale 1ns / 1ps
`default_nettype none
module rap_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_payload_byte,
    input  wire logic            i_frame_start,
    input  wire logic [12:0]     i_frame_length,
    input  wire logic [31:0]     i_frame_time,
    input  wire logic            i_frame_end,
    input  wire logic            i_full,
    output logic                 o_push,
    output rap_pkg::t_entry      o_entry
);
    import rap_pkg::*;

    logic [15:0] r_seq;
    logic [15:0] n_seq;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_entry.payload_byte = i_payload_byte;
        o_entry.frame_start  = i_frame_start;
        o_entry.frame_end    = i_frame_end;
        o_entry.frame_length = i_frame_length;
        o_entry.frame_time   = i_frame_time;
        o_entry.seq          = r_seq;
    end

    always_comb begin
        n_seq = r_seq;
        if (o_push && i_frame_start) begin
            n_seq = r_seq + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else begin
            r_seq <= n_seq;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/rap_queue.sv
// Short item queue between the front end and the packet sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rap_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rap_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_nonempty,
    output rap_pkg::t_entry      o_head
);
    import rap_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic                 do_pop;

    assign o_full     = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/rap_back.sv
// Back end: emits the 16 header bytes of a frame start, then the payload byte.
`timescale 1ns / 1ps
`default_nettype none
module rap_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rap_pkg::t_cfg   i_cfg,
    input  wire logic            i_nonempty,
    input  wire rap_pkg::t_entry i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_packet_byte,
    output logic                 o_packet_end
);
    import rap_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_end;
    logic             out_ok;
    logic             emit_payload;
    logic [7:0]       hdr_byte;
    logic [7:0]       sel_byte;

    assign out_ok       = !r_valid || i_ready;
    assign emit_payload = !i_head.frame_start || (r_pos == POS_W'(HDR_BYTES));
    assign o_pop        = i_nonempty && out_ok && emit_payload;

    always_comb begin
        case (r_pos[3:0])
            4'd0:    hdr_byte = RTP_VER_BYTE;
            4'd1:    hdr_byte = MARKER_BIT | {1'b0, i_cfg.payload_type & PT_MASK};
            4'd2:    hdr_byte = i_head.seq[15:8];
            4'd3:    hdr_byte = i_head.seq[7:0];
            4'd4:    hdr_byte = i_head.frame_time[31:24];
            4'd5:    hdr_byte = i_head.frame_time[23:16];
            4'd6:    hdr_byte = i_head.frame_time[15:8];
            4'd7:    hdr_byte = i_head.frame_time[7:0];
            4'd8:    hdr_byte = i_cfg.source_id[31:24];
            4'd9:    hdr_byte = i_cfg.source_id[23:16];
            4'd10:   hdr_byte = i_cfg.source_id[15:8];
            4'd11:   hdr_byte = i_cfg.source_id[7:0];
            4'd12:   hdr_byte = AU_HDR_LEN_HI;
            4'd13:   hdr_byte = AU_HDR_LEN_LO;
            4'd14:   hdr_byte = i_head.frame_length[12:5];
            4'd15:   hdr_byte = {i_head.frame_length[4:0] & LEN_LO_MASK, 3'b000};
            default: hdr_byte = '0;
        endcase
        sel_byte = emit_payload ? i_head.payload_byte : hdr_byte;
    end

    always_comb begin
        n_pos = r_pos;
        if (i_nonempty && out_ok && i_head.frame_start) begin
            n_pos = emit_payload ? '0 : r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (out_ok) begin
                r_valid <= i_nonempty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ok) begin
            r_byte <= sel_byte;
            r_end  <= emit_payload && i_head.frame_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_packet_byte = r_byte;
    assign o_packet_end  = r_end;

endmodule
`default_nettype wire

FILE: rtl/core/rap_checker.sv
// Port-level checker for the packetizer top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rap_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_packet_byte,
    input wire logic        o_packet_end,
    input wire logic        psel,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_packet_byte) && $stable(o_packet_end))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge i_clk)
        pready)
        else $error("pready low");

    a_pt_width: assert property (@(posedge i_clk)
        psel && !paddr[2] |-> prdata[31:7] == 25'd0)
        else $error("payload_type readback wider than 7 bits");

endmodule

bind rtp_aac_au_packetizer_core rap_checker u_rap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_packet_byte (o_packet_byte),
    .o_packet_end  (o_packet_end),
    .psel          (psel),
    .paddr         (paddr),
    .prdata        (prdata),
    .pready        (pready)
);
`default_nettype wire
